@@ design/gphe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_pkg
// Shared types and constants for the GF(2)[t] Horner evaluator.
// ----------------------------------------------------------------------------
package gphe_pkg;

  // bit steps done by one cell in each advance of the chain
  localparam int CELL_STEPS    = 4;
  // coefficient registers on the config port
  localparam int NUM_COEF_REGS = 7;
  localparam int CFG_IDX_W     = 3;

  typedef struct packed {
    logic valid;
    logic bad;      // modulus was zero
    logic one_mod;  // modulus was one, everything reduces to zero
  } gphe_ctrl_t;

endpackage

@@ design/gphe_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_in_if
// Request channel carrying an evaluation point and a modulus.
// ----------------------------------------------------------------------------
interface gphe_in_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] point;
  logic [W-1:0] modulus;

  modport source (output valid, output point, output modulus, input ready);
  modport sink   (input valid, input point, input modulus, output ready);
endinterface

@@ design/gphe_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_out_if
// Result channel carrying the reduced remainder and the bad modulus flag.
// ----------------------------------------------------------------------------
interface gphe_out_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] remainder;
  logic         bad_modulus;

  modport source (output valid, output remainder, output bad_modulus, input ready);
  modport sink   (input valid, input remainder, input bad_modulus, output ready);
endinterface

@@ design/gphe_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gphe_cfg_if import gphe_pkg::*; #(
  parameter int W = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/gphe_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_prep
// Entry stage: registers the request and finds the leading bit of the modulus.
// ----------------------------------------------------------------------------
module gphe_prep import gphe_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] point_i,
  input  logic [W-1:0] modulus_i,
  output gphe_ctrl_t   ctrl_o,
  output logic [W-1:0] v_o,
  output logic [W-1:0] l_o,
  output logic [W-1:0] hb_o
);

  localparam int LOG_W = $clog2(W);

  gphe_ctrl_t   ctrl_q, ctrl_d;
  logic [W-1:0] v_q, l_q, hb_q, hb_d;
  logic [W-1:0] smear;

  always_comb begin
    smear = modulus_i;
    for (int s = 0; s < LOG_W; s++) begin
      smear = smear | (smear >> (1 << s));
    end
    hb_d = smear ^ (smear >> 1);
    ctrl_d.valid   = valid_i;
    ctrl_d.bad     = (modulus_i == '0);
    ctrl_d.one_mod = (modulus_i == W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= point_i;
      l_q  <= modulus_i;
      hb_q <= hb_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign v_o    = v_q;
  assign l_o    = l_q;
  assign hb_o   = hb_q;

endmodule

@@ design/gphe_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_cell
// One chain cell: STEPS MSB-first steps of acc = (acc * v + c) mod l.
// ----------------------------------------------------------------------------
module gphe_cell import gphe_pkg::*; #(
  parameter int W      = 32,
  parameter int BIT_HI = 31,
  parameter int STEPS  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  gphe_ctrl_t   ctrl_i,
  input  logic [W-1:0] r_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] v_i,
  input  logic [W-1:0] l_i,
  input  logic [W-1:0] hb_i,
  input  logic [W-1:0] coef_i,
  output gphe_ctrl_t   ctrl_o,
  output logic [W-1:0] r_o,
  output logic [W-1:0] a_o,
  output logic [W-1:0] v_o,
  output logic [W-1:0] l_o,
  output logic [W-1:0] hb_o
);

  gphe_ctrl_t   ctrl_q;
  logic [W-1:0] r_q, r_d, a_q, v_q, l_q, hb_q;

  // shift, reduce on leading bit, add multiplicand, feed in coefficient bit
  always_comb begin
    r_d = r_i;
    for (int j = 0; j < STEPS; j++) begin
      r_d = {r_d[W-2:0], 1'b0};
      if (|(r_d & hb_i)) begin
        r_d = r_d ^ l_i;
      end
      if (v_i[BIT_HI-j]) begin
        r_d = r_d ^ a_i;
      end
      r_d[0] = r_d[0] ^ coef_i[BIT_HI-j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q  <= r_d;
      a_q  <= a_i;
      v_q  <= v_i;
      l_q  <= l_i;
      hb_q <= hb_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign r_o    = r_q;
  assign a_o    = a_q;
  assign v_o    = v_q;
  assign l_o    = l_q;
  assign hb_o   = hb_q;

endmodule

@@ design/gphe_out_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gphe_out_skid
// Output register plus skid entry; produces the chain advance enable.
// ----------------------------------------------------------------------------
module gphe_out_skid import gphe_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gphe_ctrl_t   ctrl_i,
  input  logic [W-1:0] r_i,
  input  logic         ready_i,
  output logic         adv_o,
  output logic         valid_o,
  output logic [W-1:0] remainder_o,
  output logic         bad_o
);

  logic         out_valid_q, skid_valid_q;
  logic [W-1:0] out_rem_q, skid_rem_q, rem_d;
  logic         out_bad_q, skid_bad_q;
  logic         adv, take_out;

  assign adv      = !skid_valid_q;
  assign take_out = !out_valid_q || ready_i;
  assign rem_d    = (ctrl_i.bad || ctrl_i.one_mod) ? '0 : r_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take_out) begin
      out_valid_q  <= skid_valid_q || ctrl_i.valid;
      skid_valid_q <= 1'b0;
    end else if (adv && ctrl_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      if (skid_valid_q) begin
        out_rem_q <= skid_rem_q;
        out_bad_q <= skid_bad_q;
      end else begin
        out_rem_q <= rem_d;
        out_bad_q <= ctrl_i.bad;
      end
    end else if (adv) begin
      skid_rem_q <= rem_d;
      skid_bad_q <= ctrl_i.bad;
    end
  end

  assign adv_o       = adv;
  assign valid_o     = out_valid_q;
  assign remainder_o = out_rem_q;
  assign bad_o       = out_bad_q;

endmodule

@@ design/gf2_poly_horner_eval_mod_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_horner_eval_mod_core
// Evaluates f(v) = sum coef_k * v^k over GF(2)[t], reduced modulo l.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the chain advances and returns f(point)
// mod modulus, where the coefficients are binary polynomials set through the
// config port (write only while idle). Each Horner term (r * v + coef) mod l
// is worked MSB first over a row of cells, four bits of v per cell, between
// the prep register and the output register; results leave one per cycle
// while the output is not stalled. A zero modulus returns 0 with bad_modulus
// set. Out-of-range register indexes are ignored.
module gf2_poly_horner_eval_mod_core import gphe_pkg::*; #(
  parameter int POLY_DEGREE = 6,
  parameter int POLY_BITS   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gphe_in_if.sink      in_if,
  gphe_out_if.source   out_if,
  gphe_cfg_if.sink     cfg_if
);

  localparam int W       = POLY_BITS;
  localparam int NTERM   = POLY_DEGREE + 1;
  localparam int CPT     = (W + CELL_STEPS - 1) / CELL_STEPS;
  localparam int NCELL   = NTERM * CPT;

  logic         adv;
  logic [W-1:0] coef [0:POLY_DEGREE];

  gphe_ctrl_t   ctrl_s [0:NCELL];
  logic [W-1:0] r_s    [0:NCELL];
  logic [W-1:0] a_s    [0:NCELL];
  logic [W-1:0] v_s    [0:NCELL];
  logic [W-1:0] l_s    [0:NCELL];
  logic [W-1:0] hb_s   [0:NCELL];

  // coefficient registers
  assign cfg_if.ready = 1'b1;

  for (genvar k = 0; k <= POLY_DEGREE; k++) begin : g_coef
    if (k < NUM_COEF_REGS) begin : g_reg
      logic [W-1:0] c_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          c_q <= (k == POLY_DEGREE) ? W'(1) : '0;
        end else if (cfg_if.valid && cfg_if.index == CFG_IDX_W'(k)) begin
          c_q <= cfg_if.data;
        end
      end
      assign coef[k] = c_q;
    end else begin : g_fixed
      assign coef[k] = W'(1);
    end
  end

  assign in_if.ready = adv;

  gphe_prep #(.W(W)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_if.valid),
    .point_i   (in_if.point),
    .modulus_i (in_if.modulus),
    .ctrl_o    (ctrl_s[0]),
    .v_o       (v_s[0]),
    .l_o       (l_s[0]),
    .hb_o      (hb_s[0])
  );

  assign r_s[0] = '0;
  assign a_s[0] = '0;

  for (genvar t = 0; t < NTERM; t++) begin : g_term
    for (genvar g = 0; g < CPT; g++) begin : g_cell
      localparam int N   = t * CPT + g;
      localparam int BHI = W - 1 - g * CELL_STEPS;
      localparam int STP = (BHI + 1 < CELL_STEPS) ? BHI + 1 : CELL_STEPS;

      logic [W-1:0] r_in, a_in;

      if (g == 0) begin : g_head
        // new term: multiplicand is the previous term's result
        assign r_in = '0;
        if (t == 0) begin : g_lead
          assign a_in = '0;
        end else begin : g_next
          assign a_in = r_s[N];
        end
      end else begin : g_body
        assign r_in = r_s[N];
        assign a_in = a_s[N];
      end

      gphe_cell #(.W(W), .BIT_HI(BHI), .STEPS(STP)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .ctrl_i (ctrl_s[N]),
        .r_i    (r_in),
        .a_i    (a_in),
        .v_i    (v_s[N]),
        .l_i    (l_s[N]),
        .hb_i   (hb_s[N]),
        .coef_i (coef[POLY_DEGREE-t]),
        .ctrl_o (ctrl_s[N+1]),
        .r_o    (r_s[N+1]),
        .a_o    (a_s[N+1]),
        .v_o    (v_s[N+1]),
        .l_o    (l_s[N+1]),
        .hb_o   (hb_s[N+1])
      );
    end
  end

  gphe_out_skid #(.W(W)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s[NCELL]),
    .r_i         (r_s[NCELL]),
    .ready_i     (out_if.ready),
    .adv_o       (adv),
    .valid_o     (out_if.valid),
    .remainder_o (out_if.remainder),
    .bad_o       (out_if.bad_modulus)
  );

endmodule

@@ bench/tb_gf2_poly_horner_eval_mod_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf2_poly_horner_eval_mod_core
// Self-checking bench for the GF(2)[t] Horner evaluator.
// ----------------------------------------------------------------------------
// Sends points and moduli with random gaps on both channels and reprograms the
// coefficient registers between phases. Each result is checked against a
// carry-less evaluation kept on the bench side, in request order.
// ----------------------------------------------------------------------------
module tb_gf2_poly_horner_eval_mod_core;
  import gphe_pkg::*;

  localparam int W           = 32;
  localparam int DEG         = 6;
  localparam int LATENCY     = 2 + (DEG + 1) * ((W + CELL_STEPS - 1) / CELL_STEPS);
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_MAX    = 13;
  localparam int PHASE_REQS  = 200;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_W'(NUM_COEF_REGS);

  typedef logic [W-1:0]   poly_t;
  typedef logic [2*W-1:0] wide_t;

  typedef struct {
    poly_t remainder;
    logic  bad;
  } eval_res_t;

  typedef enum {SET_ZERO, SET_ONES, SET_NARROW, SET_NO_LEAD, SET_RANDOM} coef_set_e;

  class horner_scoreboard;
    poly_t     coefs[DEG+1];
    eval_res_t pending[$];
    int        mismatches;
    int        checked;
    int        zero_mods;

    function new();
      foreach (coefs[k]) coefs[k] = '0;
      coefs[DEG] = 1;
      mismatches = 0;
      checked    = 0;
      zero_mods  = 0;
    endfunction

    function void write_coef(int idx, poly_t val);
      if (idx <= DEG) coefs[idx] = val;
    endfunction

    function int deg(poly_t l);
      int d;
      d = -1;
      for (int i = 0; i < W; i++) if (l[i]) d = i;
      return d;
    endfunction

    function poly_t reduce(wide_t x, poly_t l);
      int    dl;
      wide_t lx;
      dl = deg(l);
      lx = {{W{1'b0}}, l};
      for (int i = 2*W-1; i >= dl; i--) if (x[i]) x ^= lx << (i - dl);
      return x[W-1:0];
    endfunction

    function wide_t clmul(poly_t a, poly_t b);
      wide_t p;
      p = '0;
      for (int i = 0; i < W; i++) if (b[i]) p ^= {{W{1'b0}}, a} << i;
      return p;
    endfunction

    function eval_res_t evaluate(poly_t v, poly_t l);
      eval_res_t res;
      poly_t     vr;
      res.bad       = (l == '0);
      res.remainder = '0;
      if (!res.bad) begin
        vr = reduce({{W{1'b0}}, v}, l);
        res.remainder = reduce({{W{1'b0}}, coefs[DEG]}, l);
        for (int k = DEG - 1; k >= 0; k--)
          res.remainder = reduce(clmul(res.remainder, vr), l)
                          ^ reduce({{W{1'b0}}, coefs[k]}, l);
      end
      return res;
    endfunction

    function void note_request(poly_t v, poly_t l);
      pending.push_back(evaluate(v, l));
      if (l == '0) zero_mods++;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void check_result(poly_t rem, logic bad);
      eval_res_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unrequested result rem=%h bad=%b", rem, bad));
        return;
      end
      want = pending.pop_front();
      if (rem !== want.remainder || bad !== want.bad)
        report($sformatf("result %0d: rem=%h bad=%b, want rem=%h bad=%b",
                         checked, rem, bad, want.remainder, want.bad));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  horner_scoreboard sb;
  int               tx_idle;
  int               rx_idle;
  int               cycle_cnt;
  int               sent_cnt;
  int               settings_cnt;
  coef_set_e        phase_plan[NUM_PHASES] =
    '{SET_ZERO, SET_RANDOM, SET_NARROW, SET_NO_LEAD, SET_ONES, SET_RANDOM};

  gphe_in_if  #(.W(W)) req_if ();
  gphe_out_if #(.W(W)) res_if ();
  gphe_cfg_if #(.W(W)) cfg_if ();

  gf2_poly_horner_eval_mod_core #(
    .POLY_DEGREE(DEG),
    .POLY_BITS  (W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if),
    .out_if (res_if),
    .cfg_if (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic send_req(poly_t v, poly_t l);
    int gap;
    gap = $urandom_range(0, tx_idle);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.point   <= v;
    req_if.modulus <= l;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(v, l);
    sent_cnt++;
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, poly_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_coef(idx, val);
  endtask

  task automatic load_setting(coef_set_e mode);
    poly_t val;
    for (int k = 0; k <= DEG; k++) begin
      case (mode)
        SET_ZERO:    val = '0;
        SET_ONES:    val = '1;
        SET_NARROW:  val = $urandom_range(0, 255);
        SET_NO_LEAD: val = (k == DEG) ? poly_t'(0) : poly_t'($urandom);
        default:     val = $urandom;
      endcase
      write_coef(CFG_IDX_W'(k), val);
      // index past the last coefficient must be dropped
      if (k == 2) write_coef(IDX_UNUSED, $urandom);
    end
    cfg_if.valid <= 1'b0;
    settings_cnt++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int gap;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rx_idle);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      sb.check_result(res_if.remainder, res_if.bad_modulus);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, sb.pending.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    req_if.valid   <= 1'b0;
    req_if.point   <= '0;
    req_if.modulus <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    tx_idle        = IDLE_MAX;
    rx_idle        = IDLE_MAX;
    sent_cnt       = 0;
    settings_cnt   = 0;
    sb             = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: f(v) = v^6
    send_req(32'h0000_0000, 32'hFFFF_FFFF);
    send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(32'hFFFF_FFFF, 32'h0000_0000);
    send_req(32'h0000_0000, 32'h0000_0000);
    send_req(32'h1234_5678, 32'h0000_0001);
    send_req(32'hFFFF_FFFF, 32'h8000_0000);
    send_req(32'h0000_0002, 32'h0000_0013);
    send_req(32'hFFFF_FFFF, 32'h0000_0003);
    send_req(32'h8000_0000, 32'h0000_0002);
    send_req(32'h0000_001B, 32'h0000_001B);
    send_req(32'hAAAA_AAAA, 32'h5555_5555);
    wait_idle();

    // all-ones coefficients, at or above the modulus degree
    load_setting(SET_ONES);
    send_req(32'hFFFF_FFFF, 32'h0000_0007);
    send_req(32'h0000_0001, 32'h0000_0000);
    send_req(32'h0000_0000, 32'hFFFF_FFFF);
    send_req(32'hFFFF_FFFF, 32'h8000_0001);
    send_req(32'hAAAA_AAAA, 32'h0000_0001);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_setting(phase_plan[ph]);
      tx_idle = (ph % 3 == 1) ? 0 : IDLE_MAX;
      rx_idle = (ph % 3 == 2) ? 0 : IDLE_MAX;
      for (int n = 0; n < PHASE_REQS; n++) begin
        poly_t v;
        poly_t l;
        int    pick;
        int    d;
        pick = $urandom_range(0, 99);
        d    = $urandom_range(1, W - 1);
        v    = ($urandom_range(0, 19) == 0) ? poly_t'(0) : poly_t'($urandom);
        if (pick < 4)
          l = '0;
        else if (pick < 8)
          l = 1;
        else if (pick < 50)
          l = (poly_t'(1) << d) | (poly_t'($urandom) & ((poly_t'(1) << d) - 1));
        else
          l = $urandom;
        send_req(v, l);
      end
      wait_idle();
    end

    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Ran %0d requests (%0d with a zero modulus) over %0d coefficient settings.",
             sent_cnt, sb.zero_mods, settings_cnt + 1);
    $display("Compared %0d results: %0d mismatches, %0d still outstanding.",
             sb.checked, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
